FILE: rtl/rfb_pkg.sv
package rfb_pkg;

  localparam int DEF_TAPS       = 7;
  localparam int DEF_MAX_STRIDE = 8;
  localparam int DEF_LINE_DEPTH = 64;

  localparam int PIX_W   = 24;
  localparam int COEF_W  = 17;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 6;

  // Bits of the Q1.32 alpha and of its complement, stepped through by the lanes.
  localparam int MAC_BITS = 33;
  // Quotient bits: eight for the channel and one that marks an overflow.
  localparam int DIV_BITS = 9;
  // Divisor om * 2^32, aligned to the top quotient bit.
  localparam int DEN_W    = COEF_W + 32 + DIV_BITS - 1;

  localparam logic [COEF_W-1:0] Q16_ONE      = 17'h10000;
  localparam logic [COEF_W-1:0] BG_THRESHOLD = 17'd6;

  localparam logic [IDX_W-1:0] REG_COEF_CENTER  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_SIDE_1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_SIDE_2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_SIDE_3  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TAP_STRIDE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_BG_ENABLE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_BG_COLOR     = 3'd6;
  localparam logic [IDX_W-1:0] REG_INV_SAT      = 3'd7;

  typedef struct packed {
    logic start;
    logic mac;
    logic div;
  } lane_ctl_t;

endpackage

FILE: rtl/rfb_pix_if.sv
interface rfb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

FILE: rtl/rfb_res_if.sv
interface rfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       window_is_background;

  modport source (output valid, out_red, out_green, out_blue, window_is_background,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, window_is_background,
                  output ready);
endinterface

FILE: rtl/rfb_tap_cell.sv
module rfb_tap_cell
  import rfb_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  logic [PIX_W-1:0]  load_pix,
  input  logic [COEF_W-1:0] load_weight,
  input  logic [PIX_W-1:0]  next_pix,
  input  logic [COEF_W-1:0] next_weight,
  output logic [PIX_W-1:0]  pix,
  output logic [COEF_W-1:0] weight
);

  logic [PIX_W-1:0]  pix_r;
  logic [COEF_W-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r    <= load_pix;
      weight_r <= load_weight;
    end else if (shift) begin
      pix_r    <= next_pix;
      weight_r <= next_weight;
    end
  end

  assign pix    = pix_r;
  assign weight = weight_r;

endmodule

FILE: rtl/rfb_lane.sv
module rfb_lane
  import rfb_pkg::*;
#(
  parameter int ACC_W = 27
) (
  input  logic              clk,
  input  lane_ctl_t         ctl,
  input  logic [ACC_W-1:0]  acc,
  input  logic [7:0]        bg_chan,
  input  logic [COEF_W-1:0] om,
  input  logic              a_bit,
  input  logic              b_bit,
  output logic [7:0]        result
);

  localparam int NUM_W = ACC_W + 34;

  logic [NUM_W-1:0]          num_r;
  logic [24:0]               bgom_r;
  logic [DEN_W-1:0]          den_r;
  logic [DIV_BITS-1:0]       q_r;
  logic [NUM_W-1:0]          den_ext;
  logic [NUM_W-1:0]          mac_sum;
  logic                      fits;

  assign den_ext = NUM_W'(den_r);
  assign fits    = (num_r >= den_ext);
  // Horner form over the alpha bits, most significant first.
  assign mac_sum = {num_r[NUM_W-2:0], 1'b0}
                 + (a_bit ? NUM_W'(bgom_r) : '0)
                 + (b_bit ? NUM_W'(acc) : '0);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r  <= '0;
      bgom_r <= {17'd0, bg_chan} * om;
      den_r  <= {om, {(DEN_W-COEF_W){1'b0}}};
      q_r    <= '0;
    end else if (ctl.mac) begin
      num_r <= mac_sum;
    end else if (ctl.div) begin
      if (fits) begin
        num_r <= num_r - den_ext;
      end
      q_r   <= {q_r[DIV_BITS-2:0], fits};
      den_r <= den_r >> 1;
    end
  end

  assign result = q_r[DIV_BITS-1] ? 8'hFF : q_r[7:0];

endmodule

FILE: rtl/rgb_fir_background_blend_core.sv
// Channel   Dir  Handshake      Payload
// in_pix    in   valid/ready    pixel_red, pixel_green, pixel_blue
// out_res   out  valid/ready    out_red, out_green, out_blue, window_is_background
// cfg_*     in   cfg_wr_en      cfg_index, cfg_data
//
// The tap chain feeds one tap per cycle into the accumulators. In plain mode or when
// the window is background the result follows; in blend mode each lane first takes a
// start step, 33 alpha bits and 9 quotient bits. The next pixel can be accepted in the
// same cycle as the result becomes valid.
// Reset is synchronous and clears the pixel line, the configuration registers, the result valid and the control.
// A new pixel is taken while the previous result waits; a result that cannot leave
// holds the sequencer until out_res.ready.
module rgb_fir_background_blend_core
  import rfb_pkg::*;
#(
  parameter int TAPS       = DEF_TAPS,
  parameter int MAX_STRIDE = DEF_MAX_STRIDE,
  parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  rfb_pix_if.sink          in_pix,
  rfb_res_if.source        out_res,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int ACC_W = 24 + $clog2(TAPS);
  localparam int SC_W  = COEF_W + $clog2(TAPS);
  localparam int SI_W  = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int CENTER = TAPS / 2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_START = 8'b0001_0000,
    S_MAC   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [COEF_W-1:0] coef_r [4];
  logic [SI_W-1:0]   sidx_r;
  logic              bg_en_r;
  logic [PIX_W-1:0]  bg_r;
  logic [COEF_W-1:0] inv_r;

  logic [PIX_W-1:0] line_r [LINE_DEPTH];

  logic [PIX_W-1:0]  cell_pix [TAPS+1];
  logic [COEF_W-1:0] cell_w   [TAPS+1];
  logic [PIX_W-1:0]  load_pix [TAPS];
  logic [COEF_W-1:0] load_w   [TAPS];

  logic [ACC_W-1:0]    acc_r [3];
  logic [SC_W-1:0]     scale_r;
  logic [COEF_W-1:0]   sc;
  logic [COEF_W-1:0]   om_r;
  logic [MAC_BITS-1:0] a_r;
  logic [MAC_BITS-1:0] b_val;
  lane_ctl_t           lane_ctl;
  logic [7:0]          lane_res [3];
  logic [7:0]          plain_res [3];
  logic [7:0]          bg_chan [3];

  logic       out_valid_r;
  logic [7:0] res_r [3];
  logic       flag_r;
  logic       in_acc, out_free;

  assign in_acc   = in_pix.valid && in_pix.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign in_pix.ready = (state_r == S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= Q16_ONE;
      coef_r[1] <= '0;
      coef_r[2] <= '0;
      coef_r[3] <= '0;
      sidx_r    <= '0;
      bg_en_r   <= 1'b0;
      bg_r      <= '0;
      inv_r     <= Q16_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_CENTER: coef_r[0] <= (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];
        REG_COEF_SIDE_1: coef_r[1] <= (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];
        REG_COEF_SIDE_2: coef_r[2] <= (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];
        REG_COEF_SIDE_3: coef_r[3] <= (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];
        REG_TAP_STRIDE: begin
          if (cfg_data[3:0] == 4'd0) begin
            sidx_r <= '0;
          end else if ({1'b0, cfg_data[3:0]} > 5'(MAX_STRIDE)) begin
            sidx_r <= SI_W'(MAX_STRIDE - 1);
          end else begin
            sidx_r <= SI_W'(cfg_data[3:0] - 4'd1);
          end
        end
        REG_BG_ENABLE: bg_en_r <= cfg_data[0];
        REG_BG_COLOR:  bg_r    <= cfg_data[PIX_W-1:0];
        REG_INV_SAT:   inv_r   <= (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Pixel line as a shift chain: position k holds the pixel taken k items ago.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line_r[k] <= '0;
      end
    end else if (in_acc) begin
      line_r[0] <= {in_pix.pixel_red, in_pix.pixel_green, in_pix.pixel_blue};
      for (int k = 1; k < LINE_DEPTH; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign cell_pix[TAPS] = '0;
  assign cell_w[TAPS]   = '0;

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    localparam int DIST = (i >= CENTER) ? (i - CENTER) : (CENTER - i);
    logic [PIX_W-1:0] cand [MAX_STRIDE];

    for (genvar j = 0; j < MAX_STRIDE; j++) begin : g_cand
      assign cand[j] = line_r[(i * (j + 1)) % LINE_DEPTH];
    end
    assign load_pix[i] = cand[sidx_r];

    if (DIST < 4) begin : g_w
      assign load_w[i] = coef_r[DIST];
    end else begin : g_zero
      assign load_w[i] = '0;
    end

    rfb_tap_cell u_cell (
      .clk         (clk),
      .load        (state_r == S_LOAD),
      .shift       (state_r == S_ACC),
      .load_pix    (load_pix[i]),
      .load_weight (load_w[i]),
      .next_pix    (cell_pix[i+1]),
      .next_weight (cell_w[i+1]),
      .pix         (cell_pix[i]),
      .weight      (cell_w[i])
    );
  end

  // Accumulation over the chain head, then alpha and 1-scale.
  assign sc = (scale_r > SC_W'(Q16_ONE)) ? Q16_ONE : scale_r[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
      scale_r <= '0;
    end else if (state_r == S_ACC) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + ACC_W'({16'd0, cell_pix[0][16-8*c +: 8]} * cell_w[0]);
      end
      if (cell_pix[0] == bg_r) begin
        scale_r <= scale_r + SC_W'(cell_w[0]);
      end
    end
    if (state_r == S_MUL) begin
      a_r  <= MAC_BITS'({17'd0, sc} * inv_r);
      om_r <= Q16_ONE - sc;
    end
  end

  assign b_val = {1'b1, 32'd0} - a_r;

  assign lane_ctl.start = (state_r == S_START);
  assign lane_ctl.mac   = (state_r == S_MAC);
  assign lane_ctl.div   = (state_r == S_DIV);

  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign bg_chan[c] = bg_r[16-8*c +: 8];
    assign plain_res[c] = (|acc_r[c][ACC_W-1:24]) ? 8'hFF : acc_r[c][23:16];

    rfb_lane #(.ACC_W(ACC_W)) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .acc     (acc_r[c]),
      .bg_chan (bg_chan[c]),
      .om      (om_r),
      .a_bit   (a_r[cnt_r]),
      .b_bit   (b_val[cnt_r]),
      .result  (lane_res[c])
    );
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TAPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!bg_en_r || (Q16_ONE - sc) <= BG_THRESHOLD) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cnt_nxt   = CNT_W'(MAC_BITS - 1);
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(DIV_BITS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      if (!bg_en_r) begin
        res_r  <= plain_res;
        flag_r <= 1'b0;
      end else if (om_r <= BG_THRESHOLD) begin
        res_r  <= bg_chan;
        flag_r <= 1'b1;
      end else begin
        res_r  <= lane_res;
        flag_r <= 1'b0;
      end
    end
  end

  assign out_res.valid                = out_valid_r;
  assign out_res.out_red              = res_r[0];
  assign out_res.out_green            = res_r[1];
  assign out_res.out_blue             = res_r[2];
  assign out_res.window_is_background = flag_r;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_LOAD)
    else $error("accepted pixel did not start the tap load");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> cnt_r < CNT_W'(TAPS))
    else $error("tap accumulation ran past the chain");

  a_div_om: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> om_r > BG_THRESHOLD)
    else $error("division entered with a background window");

  a_flag_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flag_r |-> bg_en_r)
    else $error("background flag raised in plain mode");

endmodule
